FILE: sv/prime_sieve_engine_unit_macros.svh
// Assertion macros for the prime sieve engine.
// Included by prime_sieve_engine_unit.sv; has no other dependencies.
`ifndef PRIME_SIEVE_ENGINE_UNIT_MACROS_SVH
`define PRIME_SIEVE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pse_pkg.sv
// Shared constants for the prime sieve engine.
// No dependencies; imported by prime_sieve_engine_unit.
package pse_pkg;

  localparam int PSE_TABLE_SIZE = 1048576;
  localparam int WORD_BITS      = 16;
  localparam int LIMIT_W        = 21;
  localparam int VALUE_W        = 20;
  localparam int COUNT_W        = 21;
  localparam int FUNC_W         = 2;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1048576;

  localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd2;

endpackage

FILE: sv/prime_sieve_engine_unit.sv
// Prime sieve engine: Sieve of Eratosthenes over a word-wide composite map.
// Depends on pse_pkg and prime_sieve_engine_unit_macros.svh.
//
// Commands enter on the s_ group (s_tuser = func, s_tdata = value); one
// result word per command leaves on the m_ group. The user must write the limit
// register on the cfg_ channel only while the block is idle; it is not enforced.
// The map is kept as 16-bit words in one memory with a registered read port;
// sweeps move one word per cycle. A build clears the map up to the limit,
// then checks each base i with i*i below the limit and, for a prime base,
// marks its multiples from i*i on, merging those that share a word; then it
// counts the primes found. A test reads one word; a count sweeps the words up
// to its bound. Not built, out of range or other codes go straight to output.
// One command is worked on at a time; s_tready is high only when idle, so the
// next command is taken at the earliest the cycle after the result is loaded.
// If the receiver stalls, the next command is still taken and its result
// waits until the output register frees up. Reset sets the limit to 1048576
// and forgets any earlier build, so queries report not_built until a build
// completes. The map is not cleared by reset; each build clears what it uses.
`include "prime_sieve_engine_unit_macros.svh"

module prime_sieve_engine_unit
  import pse_pkg::*;
#(
  parameter int TABLE_SIZE = PSE_TABLE_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data,     // limit
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,      // [19:0] value, [23:20] zero
  input  logic [FUNC_W-1:0]     s_tuser,      // [1:0] func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,      // [0] prime_flag, [21:1] prime_count, rest zero
  output logic                  m_tuser       // [0] not_built
);

  localparam int CLOG_W    = $clog2(TABLE_SIZE + 1);
  localparam int NUM_W     = (CLOG_W > LIMIT_W) ? CLOG_W : LIMIT_W;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MAP_DEPTH = (TABLE_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TREAD = 14'b00000000000010,
    S_TCHK  = 14'b00000000000100,
    S_CLEAR = 14'b00000000001000,
    S_SQ    = 14'b00000000010000,
    S_SQCHK = 14'b00000000100000,
    S_IREAD = 14'b00000001000000,
    S_ICHK  = 14'b00000010000000,
    S_JREAD = 14'b00000100000000,
    S_JLOAD = 14'b00001000000000,
    S_JMARK = 14'b00010000000000,
    S_CNT   = 14'b00100000000000,
    S_CFIN  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  function automatic logic [AW-1:0] word_of(input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] sh;
    sh = n >> BIT_W;
    return sh[AW-1:0];
  endfunction

  state_t               state;
  logic [LIMIT_W-1:0]   limit;
  logic                 built;
  logic [NUM_W-1:0]     blim;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        top_word;
  logic [BIT_W-1:0]     top_bit;
  logic [NUM_W-1:0]     i;
  logic [2*NUM_W-1:0]   sq;
  logic [NUM_W:0]       j;
  logic [WORD_BITS-1:0] wbuf;
  logic [AW-1:0]        waddr;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     cnt;
  logic                 d_vld;
  logic                 d_last;
  logic                 res_prime;
  logic [NUM_W-1:0]     res_count;
  logic                 res_nb;

  logic [WORD_BITS-1:0] map_mem [MAP_DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 mem_we;

  logic [NUM_W-1:0]     lim_x;
  logic [NUM_W-1:0]     lim_eff;
  logic [NUM_W-1:0]     val_x;
  logic [NUM_W-1:0]     cnt_top;
  logic                 j_done;
  logic                 j_new_word;
  logic [BIT_W:0]       pc;
  logic                 accept;
  logic                 out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);

  // Clamp the limit register into the range the map can hold.
  always_comb begin
    lim_x = NUM_W'(limit);
    if (lim_x < NUM_W'(2)) begin
      lim_eff = NUM_W'(2);
    end else if (lim_x > NUM_W'(TABLE_SIZE)) begin
      lim_eff = NUM_W'(TABLE_SIZE);
    end else begin
      lim_eff = lim_x;
    end
  end

  assign val_x   = NUM_W'(s_tdata[VALUE_W-1:0]);
  assign cnt_top = (val_x >= blim) ? (blim - NUM_W'(1)) : val_x;

  assign j_done     = (j >= {1'b0, blim});
  assign j_new_word = (word_of(j[NUM_W-1:0]) != waddr);

  // Primes in the returned word: clear bits, masked above the bound on the last word.
  always_comb begin
    pc = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (!rd_data[k] && (!d_last || (BIT_W'(k) <= top_bit))) begin
        pc = pc + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = waddr;
    wr_data = wbuf;
    rd_addr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = ptr;
        // Word zero starts with 0 and 1 marked composite.
        wr_data = (ptr == '0) ? WORD_BITS'(3) : '0;
      end
      S_TREAD: rd_addr = word_of(num);
      S_IREAD: rd_addr = word_of(i);
      S_JREAD: rd_addr = word_of(j[NUM_W-1:0]);
      S_JMARK: begin
        rd_addr = word_of(j[NUM_W-1:0]);
        mem_we  = j_done || j_new_word;
      end
      S_CNT:   rd_addr = ptr;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      limit    <= LIMIT_RESET;
      built    <= 1'b0;
      m_tvalid <= 1'b0;
      d_vld    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_prime <= 1'b0;
            res_count <= '0;
            res_nb    <= 1'b0;
            unique case (s_tuser)
              FUNC_BUILD: begin
                blim     <= lim_eff;
                top_word <= word_of(lim_eff - NUM_W'(1));
                ptr      <= '0;
                state    <= S_CLEAR;
              end
              FUNC_TEST: begin
                num <= val_x;
                if (!built) begin
                  res_nb <= 1'b1;
                  state  <= S_OUT;
                end else if (val_x < NUM_W'(2) || val_x >= blim) begin
                  state <= S_OUT;
                end else begin
                  state <= S_TREAD;
                end
              end
              FUNC_COUNT: begin
                if (!built) begin
                  res_nb <= 1'b1;
                  state  <= S_OUT;
                end else begin
                  top_word <= word_of(cnt_top);
                  top_bit  <= cnt_top[BIT_W-1:0];
                  ptr      <= '0;
                  cnt      <= '0;
                  d_vld    <= 1'b0;
                  state    <= S_CNT;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end

        S_TREAD: state <= S_TCHK;

        S_TCHK: begin
          res_prime <= !rd_data[num[BIT_W-1:0]];
          state     <= S_OUT;
        end

        S_CLEAR: begin
          if (ptr == top_word) begin
            i     <= NUM_W'(2);
            state <= S_SQ;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end

        S_SQ: begin
          sq    <= i * i;
          state <= S_SQCHK;
        end

        S_SQCHK: begin
          if (sq >= (2*NUM_W)'(blim)) begin
            // Sieve done: count every prime below the limit.
            built    <= 1'b1;
            top_bit  <= BIT_W'(blim - NUM_W'(1));
            ptr      <= '0;
            cnt      <= '0;
            d_vld    <= 1'b0;
            state    <= S_CNT;
          end else begin
            state <= S_IREAD;
          end
        end

        S_IREAD: state <= S_ICHK;

        S_ICHK: begin
          if (rd_data[i[BIT_W-1:0]]) begin
            i     <= i + NUM_W'(1);
            state <= S_SQ;
          end else begin
            j     <= sq[NUM_W:0];
            state <= S_JREAD;
          end
        end

        S_JREAD: state <= S_JLOAD;

        S_JLOAD: begin
          wbuf  <= rd_data | (WORD_BITS'(1) << j[BIT_W-1:0]);
          waddr <= word_of(j[NUM_W-1:0]);
          j     <= j + {1'b0, i};
          state <= S_JMARK;
        end

        S_JMARK: begin
          // Multiples in the same word are merged; the word is written when j leaves it.
          if (j_done) begin
            i     <= i + NUM_W'(1);
            state <= S_SQ;
          end else if (j_new_word) begin
            state <= S_JLOAD;
          end else begin
            wbuf <= wbuf | (WORD_BITS'(1) << j[BIT_W-1:0]);
            j    <= j + {1'b0, i};
          end
        end

        S_CNT: begin
          d_vld  <= 1'b1;
          d_last <= (ptr == top_word);
          if (d_vld) begin
            cnt <= cnt + NUM_W'(pc);
          end
          if (ptr == top_word) begin
            state <= S_CFIN;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end

        S_CFIN: begin
          res_count <= cnt + NUM_W'(pc);
          d_vld     <= 1'b0;
          state     <= S_OUT;
        end

        S_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'({res_count[COUNT_W-1:0], res_prime});
            m_tuser  <= res_nb;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `PSE_ASSERT_NOW(a_nb_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "not_built result carries data")
  `PSE_ASSERT_NOW(a_we_state, clk, rst, mem_we, state == S_CLEAR || state == S_JMARK, "map written outside clear or mark")
  `PSE_ASSERT_NOW(a_cnt_ptr, clk, rst, state == S_CNT, ptr <= top_word, "count sweep ran past its last word")
  `PSE_ASSERT_NEXT(a_built_keep, clk, rst, built, built, "built flag dropped without reset")

endmodule
